// ===== src/m3i_pkg.sv =====
// shared types, widths and the cofactor index table for the 3x3 inverse core
// no dependencies
package m3i_pkg;

	localparam int ELEM_W = 32;
	localparam int FRAC_W = 16;
	localparam int PROD_W = 2 * ELEM_W;
	localparam int COF_W  = PROD_W + 1;
	localparam int LO_W   = ELEM_W + 1;
	localparam int HI_W   = COF_W - LO_W;
	localparam int PL_W   = ELEM_W + LO_W + 1;
	localparam int PH_W   = ELEM_W + HI_W;
	localparam int DET_W  = 3 * ELEM_W + 1;
	localparam int MAG_W  = 3 * ELEM_W;
	localparam int NUM_W  = PROD_W + 2 * FRAC_W;
	localparam int CMP_W  = MAG_W + ELEM_W;
	localparam int NSTEP  = ELEM_W;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [COF_W-1:0]  cof_t;
	typedef logic signed [DET_W-1:0]  det_t;
	typedef logic [MAG_W-1:0]         mag_t;
	typedef logic [NUM_W-1:0]         num_t;
	typedef logic [ELEM_W-1:0]        quo_t;

	// adjugate entry i = a[p]*a[q] - a[r]*a[s], row-major element order
	localparam int COF_IDX [9][4] = '{
		'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
		'{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
		'{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
	};

endpackage

// ===== src/matrix3x3_inverse_core.sv =====
// stages from an accepted input beat to its result beat: product/determinant stages,
// magnitude/sign, overflow check, one stage per quotient bit for 32 bits, round, clip
// throughput: one matrix per cycle; the whole pipeline halts while a result beat waits
// reset: arst_n clears only the valid bits, data registers are not reset
// top level of the 3x3 Q16.16 matrix inverse; depends on m3i_pkg and the stage modules
module matrix3x3_inverse_core import m3i_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  elem_t a11, a12, a13, a21, a22, a23, a31, a32, a33,
	output logic  out_valid,
	input  logic  out_ready,
	output elem_t q11, q12, q13, q21, q22, q23, q31, q32, q33,
	output logic  singular,
	output logic  saturated
);

	logic  en;
	elem_t a [9];
	logic  v_s2, v_s5;
	cof_t  cof_s2 [9];
	cof_t  cof_s5 [9];
	elem_t arow_s2 [3];
	det_t  det_s5;
	elem_t q [9];

	// global advance whenever the output slot is free or being taken
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	assign a = '{a11, a12, a13, a21, a22, a23, a31, a32, a33};

	m3i_cofactor u_cof (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(in_valid && en), .a(a),
		.v_s2(v_s2), .cof_s2(cof_s2), .arow_s2(arow_s2)
	);

	m3i_det u_det (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_s2), .cof(cof_s2),
		.arow(arow_s2), .v_s5(v_s5), .det_s5(det_s5), .cof_s5(cof_s5)
	);

	m3i_divider u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_s5), .det(det_s5),
		.cof(cof_s5), .v_so(out_valid), .q_so(q), .sing_so(singular),
		.sat_so(saturated)
	);

	assign q11 = q[0];
	assign q12 = q[1];
	assign q13 = q[2];
	assign q21 = q[3];
	assign q22 = q[4];
	assign q23 = q[5];
	assign q31 = q[6];
	assign q32 = q[7];
	assign q33 = q[8];

	// singular result carries no clip flag
	a_sing_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> !saturated)
		else $error("singular result flagged saturated");

	// singular result is all zero
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> (q11 == 0 && q12 == 0 && q13 == 0 && q21 == 0 &&
		q22 == 0 && q23 == 0 && q31 == 0 && q32 == 0 && q33 == 0))
		else $error("singular result not zero");

	// a stalled pipeline keeps its result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(q11) && $stable(saturated))
		else $error("result changed under stall");

endmodule

// ===== src/m3i_cofactor.sv =====
// cofactor stages: eighteen element products, then nine differences
// depends on m3i_pkg
module m3i_cofactor import m3i_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  v_in,
	input  elem_t a [9],
	output logic  v_s2,
	output cof_t  cof_s2 [9],
	output elem_t arow_s2 [3]
);

	logic  v_s1;
	prod_t pp_s1 [9];
	prod_t pm_s1 [9];
	elem_t arow_s1 [3];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
		end
	end

	// stage 1: products, stage 2: differences
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++) begin
				pp_s1[i] <= a[COF_IDX[i][0]] * a[COF_IDX[i][1]];
				pm_s1[i] <= a[COF_IDX[i][2]] * a[COF_IDX[i][3]];
				cof_s2[i] <= COF_W'(pp_s1[i]) - COF_W'(pm_s1[i]);
			end
			for (int r = 0; r < 3; r++) begin
				arow_s1[r] <= a[r];
				arow_s2[r] <= arow_s1[r];
			end
		end
	end

endmodule

// ===== src/m3i_det.sv =====
// determinant stages: split first-row products, per-term sums, final sum
// depends on m3i_pkg
module m3i_det import m3i_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  v_in,
	input  cof_t  cof [9],
	input  elem_t arow [3],
	output logic  v_s5,
	output det_t  det_s5,
	output cof_t  cof_s5 [9]
);

	logic v_s3, v_s4;
	logic signed [PL_W-1:0] pl_s3 [3];
	logic signed [PH_W-1:0] ph_s3 [3];
	det_t term_s4 [3];
	cof_t cof_s3 [9];
	cof_t cof_s4 [9];
	logic signed [HI_W-1:0] hi [3];
	logic signed [LO_W:0]   lo [3];

	// first row pairs with cofactors 0, 3 and 6
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			hi[r] = cof[3*r][COF_W-1:LO_W];
			lo[r] = {1'b0, cof[3*r][LO_W-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_in;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// partial products, recombine, sum of three terms
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				pl_s3[r] <= arow[r] * lo[r];
				ph_s3[r] <= arow[r] * hi[r];
				term_s4[r] <= (DET_W'(ph_s3[r]) <<< LO_W) + DET_W'(pl_s3[r]);
			end
			det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
			for (int i = 0; i < 9; i++) begin
				cof_s3[i] <= cof[i];
				cof_s4[i] <= cof_s3[i];
				cof_s5[i] <= cof_s4[i];
			end
		end
	end

endmodule

// ===== src/m3i_divider.sv =====
// nine restoring dividers, one quotient bit per stage, round and saturate
// depends on m3i_pkg
module m3i_divider import m3i_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  v_in,
	input  det_t  det,
	input  cof_t  cof [9],
	output logic  v_so,
	output elem_t q_so [9],
	output logic  sing_so,
	output logic  sat_so
);

	localparam logic [ELEM_W:0] LIM = (ELEM_W+1)'(1) << (ELEM_W - 1);

	logic v_s6, v_sr;
	mag_t d_s6;
	num_t num_s6 [9];
	logic neg_s6 [9];
	logic sing_s6;

	// per-step registers, index 0 is the stage before the first step
	logic v_s    [NSTEP+1];
	mag_t d_s    [NSTEP+1];
	logic sing_s [NSTEP+1];
	num_t rem_s  [NSTEP+1][9];
	quo_t quo_s  [NSTEP+1][9];
	logic neg_s  [NSTEP+1][9];
	logic ovf_s  [NSTEP+1][9];

	logic [ELEM_W:0] qr_sr [9];
	logic neg_sr [9];
	logic ovf_sr [9];
	logic sing_sr;

	logic            sat_e [9];
	logic            sat_any;
	logic [ELEM_W:0] neg_q [9];
	det_t            det_neg;
	cof_t            cof_neg [9];

	always_comb begin
		det_neg = -det;
		sat_any = 1'b0;
		for (int i = 0; i < 9; i++) begin
			cof_neg[i] = -cof[i];
			sat_e[i] = ovf_sr[i] ||
				(neg_sr[i] ? (qr_sr[i] > LIM) : (qr_sr[i] >= LIM));
			neg_q[i] = -qr_sr[i];
			sat_any = sat_any | sat_e[i];
		end
	end

	// control valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s[0] <= 1'b0;
			v_sr <= 1'b0;
			v_so <= 1'b0;
		end else if (en) begin
			v_s6 <= v_in;
			v_s[0] <= v_s6;
			v_sr <= v_s[NSTEP];
			v_so <= v_sr;
		end
	end

	// magnitudes and signs, then the overflow precheck
	always_ff @(posedge clk) begin
		if (en) begin
			d_s6 <= det[DET_W-1] ? det_neg[MAG_W-1:0] : det[MAG_W-1:0];
			sing_s6 <= (det == '0);
			for (int i = 0; i < 9; i++) begin
				num_s6[i] <= NUM_W'(cof[i][COF_W-1] ? cof_neg[i][PROD_W-1:0]
					: cof[i][PROD_W-1:0]) << (2 * FRAC_W);
				neg_s6[i] <= cof[i][COF_W-1] ^ det[DET_W-1];
			end
			d_s[0] <= d_s6;
			sing_s[0] <= sing_s6;
			for (int i = 0; i < 9; i++) begin
				rem_s[0][i] <= num_s6[i];
				quo_s[0][i] <= '0;
				neg_s[0][i] <= neg_s6[i];
				ovf_s[0][i] <= CMP_W'(num_s6[i]) >= (CMP_W'(d_s6) << ELEM_W);
			end
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar j = 0; j < NSTEP; j++) begin : g_step
		localparam int K = NSTEP - 1 - j;
		logic [CMP_W-1:0] dsh;
		logic             geq [9];
		logic [CMP_W-1:0] diff [9];

		always_comb begin
			dsh = CMP_W'(d_s[j]) << K;
			for (int i = 0; i < 9; i++) begin
				geq[i] = CMP_W'(rem_s[j][i]) >= dsh;
				diff[i] = CMP_W'(rem_s[j][i]) - dsh;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d_s[j+1] <= d_s[j];
				sing_s[j+1] <= sing_s[j];
				for (int i = 0; i < 9; i++) begin
					rem_s[j+1][i] <= geq[i] ? diff[i][NUM_W-1:0] : rem_s[j][i];
					quo_s[j+1][i] <= {quo_s[j][i][ELEM_W-2:0], geq[i]};
					neg_s[j+1][i] <= neg_s[j][i];
					ovf_s[j+1][i] <= ovf_s[j][i];
				end
			end
		end
	end

	// round half away from zero, then sign and clip
	always_ff @(posedge clk) begin
		if (en) begin
			sing_sr <= sing_s[NSTEP];
			for (int i = 0; i < 9; i++) begin
				qr_sr[i] <= (ELEM_W+1)'(quo_s[NSTEP][i]) + (ELEM_W+1)'(
					(CMP_W'(rem_s[NSTEP][i]) << 1) >= CMP_W'(d_s[NSTEP]));
				neg_sr[i] <= neg_s[NSTEP][i];
				ovf_sr[i] <= ovf_s[NSTEP][i];
			end
			sing_so <= sing_sr;
			sat_so <= !sing_sr && sat_any;
			for (int i = 0; i < 9; i++) begin
				if (sing_sr) begin
					q_so[i] <= '0;
				end else if (sat_e[i]) begin
					q_so[i] <= neg_sr[i] ? elem_t'(LIM[ELEM_W-1:0])
						: elem_t'(LIM[ELEM_W-1:0] - 1'b1);
				end else begin
					q_so[i] <= neg_sr[i] ? elem_t'(neg_q[i][ELEM_W-1:0])
						: elem_t'(qr_sr[i][ELEM_W-1:0]);
				end
			end
		end
	end

endmodule

// ===== verif/tb_matrix3x3_inverse_core.sv =====
// self-checking testbench for matrix3x3_inverse_core: random and directed matrices,
// exact wide-integer prediction of the adjugate/determinant inverse, random stalls
// depends on m3i_pkg and the core RTL
`timescale 1ns / 100ps

module tb_matrix3x3_inverse_core;
	import m3i_pkg::*;

	typedef logic signed [127:0] wide_t;
	typedef elem_t mat_t [9];
	typedef struct {
		elem_t q [9];
		logic  singular;
		logic  saturated;
	} inv_t;

	logic  clk = 0;
	logic  arst_n = 0;
	logic  in_valid = 0;
	logic  in_ready;
	elem_t a [9];
	logic  out_valid;
	logic  out_ready = 0;
	elem_t q [9];
	logic  singular, saturated;

	inv_t  inverse_q [$];
	int    err_cnt = 0;
	int    cycle_cnt = 0;
	bit    quiet = 0;
	bit    holdoff = 0;

	initial for (int i = 0; i < 9; i++) a[i] = '0;

	matrix3x3_inverse_core dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.a11(a[0]), .a12(a[1]), .a13(a[2]), .a21(a[3]), .a22(a[4]), .a23(a[5]),
		.a31(a[6]), .a32(a[7]), .a33(a[8]),
		.out_valid(out_valid), .out_ready(out_ready),
		.q11(q[0]), .q12(q[1]), .q13(q[2]), .q21(q[3]), .q22(q[4]), .q23(q[5]),
		.q31(q[6]), .q32(q[7]), .q33(q[8]),
		.singular(singular), .saturated(saturated)
	);

	// clock
	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > 400000) begin
			$display("status: fail");
			$finish;
		end
	end

	// exact inverse: cofactors and determinant in wide integers, rounded quotient
	function automatic inv_t predict_inverse(mat_t m);
		inv_t  r;
		wide_t cof [9];
		wide_t det;
		logic [127:0] num, den, quo, rem;
		logic  neg;
		for (int i = 0; i < 9; i++)
			cof[i] = wide_t'(m[COF_IDX[i][0]]) * wide_t'(m[COF_IDX[i][1]])
				- wide_t'(m[COF_IDX[i][2]]) * wide_t'(m[COF_IDX[i][3]]);
		det = wide_t'(m[0]) * cof[0] + wide_t'(m[1]) * cof[3] + wide_t'(m[2]) * cof[6];
		r.singular = (det == 0);
		r.saturated = 0;
		for (int i = 0; i < 9; i++) begin
			if (r.singular) begin
				r.q[i] = '0;
				continue;
			end
			neg = cof[i][127] ^ det[127];
			num = (cof[i] < 0 ? -cof[i] : cof[i]) << (2 * FRAC_W);
			den = det < 0 ? -det : det;
			quo = num / den;
			rem = num % den;
			if ((rem << 1) >= den)
				quo = quo + 1;
			if (neg) begin
				if (quo > (128'd1 << (ELEM_W - 1))) begin
					r.saturated = 1;
					r.q[i] = {1'b1, {(ELEM_W-1){1'b0}}};
				end else
					r.q[i] = elem_t'(-quo);
			end else if (quo >= (128'd1 << (ELEM_W - 1))) begin
				r.saturated = 1;
				r.q[i] = {1'b0, {(ELEM_W-1){1'b1}}};
			end else
				r.q[i] = elem_t'(quo);
		end
		return r;
	endfunction

	// input beats: record the predicted inverse
	always @(posedge clk)
		if (in_valid && in_ready)
			inverse_q.push_back(predict_inverse(a));

	// result beats: compare against the oldest prediction
	always @(posedge clk) begin
		inv_t exp_r;
		if (out_valid && out_ready) begin
			if (inverse_q.size() == 0) begin
				$error("result beat with no matrix outstanding");
				err_cnt++;
			end else begin
				exp_r = inverse_q.pop_front();
				for (int i = 0; i < 9; i++)
					if (q[i] !== exp_r.q[i]) begin
						$error("q%0d%0d expected %h actual %h", i / 3 + 1, i % 3 + 1,
							exp_r.q[i], q[i]);
						err_cnt++;
					end
				if (singular !== exp_r.singular) begin
					$error("singular expected %b actual %b", exp_r.singular, singular);
					err_cnt++;
				end
				if (saturated !== exp_r.saturated) begin
					$error("saturated expected %b actual %b", exp_r.saturated, saturated);
					err_cnt++;
				end
			end
		end
	end

	// receiver stalls
	always @(negedge clk)
		out_ready <= holdoff ? 1'b0 : (quiet ? 1'b1 : ($urandom_range(99) >= 16));

	task automatic send_matrix(mat_t m);
		while (!quiet && $urandom_range(99) < 16) begin
			@(negedge clk);
			in_valid <= 0;
		end
		@(negedge clk);
		in_valid <= 1;
		for (int i = 0; i < 9; i++)
			a[i] <= m[i];
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic mat_t diag(elem_t x, elem_t y, elem_t z);
		mat_t m;
		foreach (m[i]) m[i] = '0;
		m[0] = x; m[4] = y; m[8] = z;
		return m;
	endfunction

	function automatic mat_t rand_matrix();
		mat_t m;
		int kind = $urandom_range(99);
		foreach (m[i]) begin
			if (kind < 40)
				m[i] = $urandom;
			else if (kind < 75)
				m[i] = (int'($urandom_range(8)) - 4) * 65536 + int'($urandom_range(65535));
			else
				m[i] = $urandom_range(1) ? {1'b0, {31{1'b1}}} - $urandom_range(3)
					: {1'b1, 31'b0} + $urandom_range(3);
		end
		// well-conditioned: boost the diagonal
		if (kind >= 40 && kind < 60) begin
			m[0] += 32'sd8 << 16; m[4] += 32'sd8 << 16; m[8] += 32'sd8 << 16;
		end
		// last row: each element copies the first row or negates the second row
		if ($urandom_range(99) < 15)
			for (int c = 0; c < 3; c++)
				m[6 + c] = $urandom_range(1) ? m[c] : -m[3 + c];
		return m;
	endfunction

	task automatic test_directed();
		mat_t m;
		elem_t mx = {1'b0, {31{1'b1}}};
		elem_t mn = {1'b1, 31'b0};
		send_matrix(diag(32'sh10000, 32'sh10000, 32'sh10000));
		send_matrix(diag(0, 0, 0));
		send_matrix(diag(32'sh30000, -32'sh20000, 32'sh70000));
		send_matrix(diag(mx, mx, mx));
		send_matrix(diag(mn, mn, mn));
		send_matrix(diag(1, 1, 1));
		send_matrix(diag(-1, 1, -1));
		send_matrix(diag(mx, 1, mn));
		foreach (m[i]) m[i] = mx;
		send_matrix(m);
		foreach (m[i]) m[i] = mn;
		send_matrix(m);
		foreach (m[i]) m[i] = (i % 2) ? mn : mx;
		send_matrix(m);
		foreach (m[i]) m[i] = (i + 1) * 32'sh10000;
		send_matrix(m);
		m[8] = 32'sh10000;
		send_matrix(m);
		m = diag(32'sh10000, 32'sh10000, 32'sh10000);
		m[1] = 32'sh20000; m[5] = -32'sh30000; m[6] = 32'sh8000;
		send_matrix(m);
		m = diag(0, 0, 0);
		m[2] = 32'sh10000; m[4] = 32'sh10000; m[6] = 32'sh10000;
		send_matrix(m);
	endtask

	task automatic test_random(int n);
		repeat (n) send_matrix(rand_matrix());
	endtask

	task automatic test_quiet_stream(int n);
		quiet = 1;
		test_random(n);
		quiet = 0;
	endtask

	// receiver holds off long enough to fill the pipeline
	task automatic test_backpressure();
		holdoff = 1;
		fork
			begin
				repeat (150) @(posedge clk);
				holdoff = 0;
			end
			test_random(80);
		join
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		test_directed();
		test_random(400);
		test_quiet_stream(200);
		test_backpressure();
		test_random(300);
		@(negedge clk);
		in_valid <= 0;
		while (inverse_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (err_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== matrix3x3_inverse_core.f =====
src/m3i_pkg.sv
src/m3i_cofactor.sv
src/m3i_det.sv
src/m3i_divider.sv
src/matrix3x3_inverse_core.sv
verif/tb_matrix3x3_inverse_core.sv
